[rtl/row_bitmap_to_page_bytes_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the row bitmap to page bytes unit
// Shared property forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ROW_BITMAP_TO_PAGE_BYTES_UNIT_MACROS_SVH
`define ROW_BITMAP_TO_PAGE_BYTES_UNIT_MACROS_SVH

// Same-cycle implication.
`define RBP_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication.
`define RBP_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

[rtl/rbp_pkg.sv]
// ----------------------------------------------------------------------------
// rbp_pkg
// Geometry constants and helpers for the row bitmap to page bytes unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rbp_pkg;

  localparam int DISPLAY_WIDTH = 128;
  localparam int PAGE_COUNT    = 8;

  localparam int BYTES_PER_ROW = (DISPLAY_WIDTH / 8) > 0 ? (DISPLAY_WIDTH / 8) : 1;
  localparam int STORED_ROWS   = 7;
  localparam int COL_W  = BYTES_PER_ROW > 1 ? $clog2(BYTES_PER_ROW) : 1;
  localparam int PAGE_W = PAGE_COUNT > 1 ? $clog2(PAGE_COUNT) : 1;

  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(BYTES_PER_ROW - 1);
  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGE_COUNT - 1);
  localparam logic [2:0]        LAST_ROW  = 3'd7;

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [8*STORED_ROWS-1:0] store_word_t;

  // Pixel column of the first byte of a byte column, wrapped to 7 bits.
  function automatic logic [6:0] column_base(input col_t col);
    logic [31:0] t;
    t = 32'(col) << 3;
    return t[6:0];
  endfunction

  // Page number wrapped to the 3-bit output field.
  function automatic logic [2:0] page_field(input page_t page);
    logic [31:0] t;
    t = 32'(page);
    return t[2:0];
  endfunction

endpackage

`default_nettype wire

[rtl/row_bitmap_to_page_bytes_unit.sv]
// ----------------------------------------------------------------------------
// row_bitmap_to_page_bytes_unit
// Converts row-major monochrome pixel bytes into page-addressed column bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one byte of eight horizontal pixels per transaction,
//   leftmost pixel in bit 7, rows in order, frame after frame.
//   Output stream (m_*): column bytes, top row of the page in bit 0, eight per
//   byte of the eighth row of a page, columns ascending. tlast marks the last
//   column byte of a tile, tuser the last column byte of the frame.
//   Rows 0..6 of a page are written into a store memory, one entry per byte
//   column holding seven row lanes. A byte of row 7 reads that entry into a
//   register, is transposed into a tile buffer and then sent out. m_tvalid
//   rises once a row 7 byte has passed the holding stage into a free tile
//   buffer. Throughput: rows 0..6 take one cycle per byte while the holding
//   stage does not block input; a row 7 byte becomes a tile of eight column
//   bytes that the single output port drains from the tile buffer. The first
//   bytes of the next page wait until the last tile leaves the holding stage.
//   One further tile waits in a holding stage while the buffer drains, so
//   input is accepted during an output stall until that stage is full.
//   Reset clears the row, column and page counters and empties both stages;
//   the store is not cleared, every entry is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module row_bitmap_to_page_bytes_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] pixel_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] column_byte, [14:8] column_index,
                                      // [17:15] page_index, [23:18] zero
  output logic             m_tlast,   // last_of_tile
  output logic             m_tuser    // end_of_frame
);
  import rbp_pkg::*;

  `include "row_bitmap_to_page_bytes_unit_macros.svh"

  store_word_t row_store [BYTES_PER_ROW];

  logic [2:0] row_in_page;
  col_t       byte_column;
  page_t      current_page;

  // Holding stage: one row 7 byte with its store entry.
  logic        s1_valid;
  logic [7:0]  s1_byte;
  store_word_t rd_data;
  logic [6:0]  s1_base;
  logic [2:0]  s1_page;
  logic        s1_eof;

  // Tile buffer and output sequencer.
  logic       ser_valid;
  logic [2:0] ser_k;
  logic [7:0] tile [8];
  logic [6:0] ser_base;
  logic [2:0] ser_page;
  logic       ser_eof;

  logic       in_acc;
  logic       out_acc;
  logic       load;
  logic [7:0] col_bytes [8];

  assign out_acc  = m_tvalid && m_tready;
  assign load     = s1_valid && (!ser_valid || (out_acc && ser_k == LAST_ROW));
  assign s_tready = !s1_valid || load;
  assign in_acc   = s_tvalid && s_tready;

  // Store: write the row lane on rows 0..6, read the whole entry on row 7.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (row_in_page == LAST_ROW) begin
        rd_data <= row_store[byte_column];
      end else begin
        row_store[byte_column][8*row_in_page +: 8] <= s_tdata;
      end
    end
  end

  // Position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_in_page  <= '0;
      byte_column  <= '0;
      current_page <= '0;
    end else if (in_acc) begin
      if (byte_column == LAST_COL) begin
        byte_column <= '0;
        row_in_page <= row_in_page + 3'd1;
        if (row_in_page == LAST_ROW) begin
          current_page <= (current_page == LAST_PAGE) ? '0 : current_page + 1'b1;
        end
      end else begin
        byte_column <= byte_column + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc && row_in_page == LAST_ROW) begin
      s1_valid <= 1'b1;
    end else if (load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && row_in_page == LAST_ROW) begin
      s1_byte <= s_tdata;
      s1_base <= column_base(byte_column);
      s1_page <= page_field(current_page);
      s1_eof  <= (byte_column == LAST_COL) && (current_page == LAST_PAGE);
    end
  end

  // Transpose: column k takes bit 7-k of every row, row n lands in bit n.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      for (int n = 0; n < STORED_ROWS; n++) begin
        col_bytes[k][n] = rd_data[8*n + 7 - k];
      end
      col_bytes[k][7] = s1_byte[7 - k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_k     <= '0;
    end else if (load) begin
      ser_valid <= 1'b1;
      ser_k     <= '0;
    end else if (out_acc) begin
      ser_k <= ser_k + 3'd1;
      if (ser_k == LAST_ROW) begin
        ser_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < 8; k++) begin
        tile[k] <= col_bytes[k];
      end
      ser_base <= s1_base;
      ser_page <= s1_page;
      ser_eof  <= s1_eof;
    end
  end

  // Base has its low three bits clear, so the column index is a plain OR.
  assign m_tvalid = ser_valid;
  assign m_tdata  = {6'b000000, ser_page, ser_base | {4'b0000, ser_k}, tile[ser_k]};
  assign m_tlast  = (ser_k == LAST_ROW);
  assign m_tuser  = ser_eof && (ser_k == LAST_ROW);

  `RBP_ASSERT_NOW(a_stall_needs_full_stage, !s_tready, s1_valid,
                  "input stalled with empty holding stage")
  `RBP_ASSERT_NEXT(a_load_starts_tile, load, ser_valid && ser_k == 3'd0,
                   "tile load did not restart the sequencer")
  `RBP_ASSERT_NEXT(a_stall_holds_column, ser_valid && !m_tready,
                   ser_valid && $stable(ser_k),
                   "column sequencer moved during output stall")
  `RBP_ASSERT_NOW(a_eof_on_tile_end, m_tvalid && m_tuser, m_tlast,
                  "end of frame outside last column of a tile")

endmodule

`default_nettype wire
